FILE: rtl/oaids_pkg.sv
// Shared field widths, request kinds and status codes for the ordered array block.
package oaids_pkg;

	localparam int KIND_W = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		K_CLEAR  = 3'd0,
		K_APPEND = 3'd1,
		K_READ   = 3'd2,
		K_INSERT = 3'd3,
		K_DELETE = 3'd4,
		K_SEARCH = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

FILE: rtl/ordered_array_insert_delete_search.sv
// Top level of the packed word array with insert, delete, read and linear search.
// Each request is taken only while in_ready is high and yields exactly one result on the
// output channel. Clear, append, an insert into a full store, a request with a bad position
// and an unknown kind go straight from input transfer to the result without a walk. Read
// fetches its one word through the memory read port. Insert and delete walk the words that
// move through the single memory read port, one word per cycle, each word being written
// back in the cycle after its read. Search walks from position zero and stops at the first
// match. The store itself needs no clearing after reset.
module ordered_array_insert_delete_search #(
	parameter int DEPTH      = 64,
	parameter int WORD_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [oaids_pkg::KIND_W-1:0] kind,
	input  logic [oaids_pkg::POS_W-1:0]  position,
	input  logic [oaids_pkg::VAL_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [oaids_pkg::STAT_W-1:0] status,
	output logic [oaids_pkg::VAL_W-1:0]  data,
	output logic [oaids_pkg::IDX_W-1:0]  found_index,
	output logic [oaids_pkg::CNT_W-1:0]  count
);
	import oaids_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	state_t                state_q;
	kind_t                 op_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         left_q;
	logic [AW-1:0]         raddr_q;
	logic [AW-1:0]         paddr_q;
	logic                  pend_q;
	status_t               status_q;
	logic [VAL_W-1:0]      data_q;
	logic [IDX_W-1:0]      found_q;

	logic                  in_xfer;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         fill_x;
	logic                  full;
	logic [WORD_WIDTH-1:0] word_in;
	logic                  finish;
	logic                  hit;
	logic                  rd_en;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [WORD_WIDTH-1:0] rd_data;

	function automatic logic [VAL_W-1:0] to_data(logic [WORD_WIDTH-1:0] w);
		logic [63:0] e;
		e = {64{w[WORD_WIDTH-1]}};
		e[WORD_WIDTH-1:0] = w;
		return e[VAL_W-1:0];
	endfunction

	function automatic logic [WORD_WIDTH-1:0] to_word(logic [VAL_W-1:0] v);
		logic [63:0] e;
		e = {64{v[VAL_W-1]}};
		e[VAL_W-1:0] = v;
		return e[WORD_WIDTH-1:0];
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign in_xfer   = in_valid && in_ready;
	assign pos_x     = XW'(position);
	assign fill_x    = XW'(fill_q);
	assign full      = (fill_q >= CW'(DEPTH));
	assign word_in   = to_word(value);

	// The walk ends once no read is left to issue and the last read word has been used.
	assign finish = (state_q == S_RUN) && (left_q == '0) && !pend_q;
	assign hit    = (state_q == S_RUN) && pend_q && (op_q == K_SEARCH) && (rd_data == word_q);
	assign rd_en  = (state_q == S_RUN) && (left_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = paddr_q;
		wr_data = rd_data;
		if (in_xfer && (kind_t'(kind) == K_APPEND) && !full) begin
			wr_en   = 1'b1;
			wr_addr = AW'(fill_q);
			wr_data = word_in;
		end else if (state_q == S_RUN && pend_q && op_q == K_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = paddr_q + AW'(1);
		end else if (state_q == S_RUN && pend_q && op_q == K_DELETE) begin
			wr_en   = 1'b1;
			wr_addr = paddr_q - AW'(1);
		end else if (finish && op_q == K_INSERT) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = word_q;
		end
	end

	oaids_mem #(
		.DEPTH (DEPTH),
		.WIDTH (WORD_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (raddr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= K_CLEAR;
			word_q   <= '0;
			pos_q    <= '0;
			fill_q   <= '0;
			left_q   <= '0;
			raddr_q  <= '0;
			paddr_q  <= '0;
			pend_q   <= 1'b0;
			status_q <= ST_OK;
			data_q   <= '0;
			found_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q     <= kind_t'(kind);
						word_q   <= word_in;
						pos_q    <= AW'(pos_x);
						pend_q   <= 1'b0;
						status_q <= ST_OK;
						data_q   <= '0;
						found_q  <= '0;
						state_q  <= S_DONE;
						case (kind_t'(kind))
							K_CLEAR: begin
								fill_q <= '0;
							end
							K_APPEND: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									fill_q <= fill_q + CW'(1);
								end
							end
							K_READ: begin
								if (pos_x >= fill_x) begin
									status_q <= ST_BAD_POS;
								end else begin
									raddr_q <= AW'(pos_x);
									left_q  <= CW'(1);
									state_q <= S_RUN;
								end
							end
							K_INSERT: begin
								if (pos_x > fill_x) begin
									status_q <= ST_BAD_POS;
								end else if (full) begin
									status_q <= ST_FULL;
								end else begin
									// Words move up starting from the top one.
									raddr_q <= AW'(fill_x - XW'(1));
									left_q  <= CW'(fill_x - pos_x);
									state_q <= S_RUN;
								end
							end
							K_DELETE: begin
								if (pos_x >= fill_x) begin
									status_q <= ST_BAD_POS;
								end else begin
									raddr_q <= AW'(pos_x + XW'(1));
									left_q  <= CW'(fill_x - pos_x - XW'(1));
									state_q <= S_RUN;
								end
							end
							K_SEARCH: begin
								raddr_q <= '0;
								left_q  <= fill_q;
								state_q <= S_RUN;
							end
							default: begin
							end
						endcase
					end
				end
				S_RUN: begin
					if (left_q != '0) begin
						raddr_q <= (op_q == K_INSERT) ? raddr_q - AW'(1) : raddr_q + AW'(1);
						left_q  <= left_q - CW'(1);
						paddr_q <= raddr_q;
						pend_q  <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && op_q == K_READ) begin
						data_q <= to_data(rd_data);
					end
					if (hit) begin
						found_q <= IDX_W'(paddr_q);
						state_q <= S_DONE;
					end
					if (finish) begin
						state_q <= S_DONE;
						case (op_q)
							K_INSERT: fill_q   <= fill_q + CW'(1);
							K_DELETE: fill_q   <= fill_q - CW'(1);
							K_SEARCH: status_q <= ST_NOT_FOUND;
							default: begin
							end
						endcase
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign data        = data_q;
	assign found_index = found_q;
	assign count       = CNT_W'(fill_q);

`ifndef SYNTH
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while a result is waiting");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count beyond capacity");

	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("not ready after result transfer");

	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !in_ready && !out_valid)
		else $error("memory read outside the walk");
`endif

endmodule

FILE: rtl/oaids_mem.sv
// Word store with one write port and one registered read port.
module oaids_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
